[rtl/core/mexp_pkg.sv]
// mexp_pkg: shared widths, microcode control word types and the microprogram
// for the modular exponentiation block. No dependencies.
`default_nettype none

package mexp_pkg;

    // datapath width and fixed field widths
    localparam int MEXP_WIDTH = 32;
    localparam int FIELD_W    = 32;
    localparam int CFG_ADDR_W = 1;
    localparam int PC_W       = 4;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MODULUS  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_EXPONENT = 1'b1;

    // microprogram step addresses
    localparam logic [PC_W-1:0] PC_IDLE    = 4'd0;
    localparam logic [PC_W-1:0] PC_RED     = 4'd1;
    localparam logic [PC_W-1:0] PC_RED_W   = 4'd2;
    localparam logic [PC_W-1:0] PC_TEST_Z  = 4'd3;
    localparam logic [PC_W-1:0] PC_TEST_B  = 4'd4;
    localparam logic [PC_W-1:0] PC_MUL     = 4'd5;
    localparam logic [PC_W-1:0] PC_MUL_W   = 4'd6;
    localparam logic [PC_W-1:0] PC_SQR     = 4'd7;
    localparam logic [PC_W-1:0] PC_SQR_W   = 4'd8;
    localparam logic [PC_W-1:0] PC_EMIT    = 4'd9;

    // micro-operations
    typedef enum logic [2:0] {
        OP_ACCEPT,  // wait for an input beat, load the working registers
        OP_MUL,     // start the modular multiplier
        OP_WAIT,    // wait for the multiplier, write back the product
        OP_BRZ,     // jump when no exponent bits remain
        OP_BRE,     // jump when the current exponent bit is zero
        OP_EMIT     // hand the accumulator to the output register
    } op_t;

    typedef enum logic [1:0] {
        OPND_ONE,
        OPND_RS,
        OPND_ACC
    } opnd_t;

    typedef enum logic [1:0] {
        DST_NONE,
        DST_RS,
        DST_ACC
    } dst_t;

    typedef struct packed {
        op_t             op;
        opnd_t           a_sel;
        opnd_t           b_sel;
        dst_t            dst;
        logic            shift_el;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_fire;
        logic mul_done;
        logic el_zero;
        logic el_lsb;
        logic out_free;
    } stat_t;

    // microprogram rom
    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{OP_ACCEPT, OPND_ONE, OPND_RS, DST_NONE, 1'b0, PC_RED};
        unique case (pc)
            PC_IDLE:   w = '{OP_ACCEPT, OPND_ONE, OPND_RS,  DST_NONE, 1'b0, PC_RED};
            PC_RED:    w = '{OP_MUL,    OPND_ONE, OPND_RS,  DST_NONE, 1'b0, PC_RED_W};
            PC_RED_W:  w = '{OP_WAIT,   OPND_ONE, OPND_RS,  DST_RS,   1'b0, PC_TEST_Z};
            PC_TEST_Z: w = '{OP_BRZ,    OPND_ONE, OPND_RS,  DST_NONE, 1'b0, PC_EMIT};
            PC_TEST_B: w = '{OP_BRE,    OPND_ONE, OPND_RS,  DST_NONE, 1'b0, PC_SQR};
            PC_MUL:    w = '{OP_MUL,    OPND_RS,  OPND_ACC, DST_NONE, 1'b0, PC_MUL_W};
            PC_MUL_W:  w = '{OP_WAIT,   OPND_RS,  OPND_ACC, DST_ACC,  1'b0, PC_SQR};
            PC_SQR:    w = '{OP_MUL,    OPND_RS,  OPND_RS,  DST_NONE, 1'b0, PC_SQR_W};
            PC_SQR_W:  w = '{OP_WAIT,   OPND_RS,  OPND_RS,  DST_RS,   1'b1, PC_TEST_Z};
            PC_EMIT:   w = '{OP_EMIT,   OPND_ONE, OPND_RS,  DST_NONE, 1'b0, PC_IDLE};
            default:   w = '{OP_ACCEPT, OPND_ONE, OPND_RS,  DST_NONE, 1'b0, PC_RED};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/core/mexp_modmul.sv]
// mexp_modmul: bit-serial modular multiplier, one multiplier bit per cycle,
// msb first, running sum kept below the modulus. Depends on mexp_pkg.
`default_nettype none

module mexp_modmul
    import mexp_pkg::*;
#(
    parameter int WIDTH = MEXP_WIDTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] op_a,     // must be below the modulus
    input  wire logic [WIDTH-1:0] op_b,     // any value
    input  wire logic [WIDTH-1:0] modulus,  // zero means 2^WIDTH
    output logic                  done,
    output logic      [WIDTH-1:0] product
);

    localparam int CW = $clog2(WIDTH);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] m_reg, m_next;
    logic [WIDTH-1:0] r_reg, r_next;
    logic [WIDTH-1:0] dbl;
    logic [WIDTH-1:0] step;

    // (x + y) mod m for x, y below m; m of zero wraps
    function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                                 input logic [WIDTH-1:0] y,
                                                 input logic [WIDTH-1:0] m);
        logic [WIDTH:0] s;
        logic [WIDTH:0] d;
        s = {1'b0, x} + {1'b0, y};
        d = s - {1'b0, m};
        if (m == '0) begin
            return s[WIDTH-1:0];
        end else if (s >= {1'b0, m}) begin
            return d[WIDTH-1:0];
        end
        return s[WIDTH-1:0];
    endfunction

    // one double-and-add step
    always_comb begin
        dbl  = add_mod(r_reg, r_reg, m_reg);
        step = b_reg[WIDTH-1] ? add_mod(dbl, a_reg, m_reg) : dbl;
    end

    // iteration control
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(WIDTH - 1);
            a_next    = op_a;
            b_next    = op_b;
            m_next    = modulus;
            r_next    = '0;
        end else if (busy_reg) begin
            r_next = step;
            b_next = {b_reg[WIDTH-2:0], 1'b0};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        r_reg   <= r_next;
    end

    assign done    = done_reg;
    assign product = r_reg;

endmodule

`default_nettype wire

[rtl/core/mexp_useq.sv]
// mexp_useq: step counter and microprogram rom; issues one control word per
// step and resolves waits and conditional jumps. Depends on mexp_pkg.
`default_nettype none

module mexp_useq
    import mexp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire stat_t      stat,
    output ctrl_word_t      ctrl
);

    logic [PC_W-1:0] pc_reg, pc_next;

    assign ctrl = ucode(pc_reg);

    // next step: stall, jump or fall through
    always_comb begin
        pc_next = pc_reg;
        unique case (ctrl.op)
            OP_ACCEPT: if (stat.in_fire)  pc_next = ctrl.target;
            OP_MUL:    pc_next = ctrl.target;
            OP_WAIT:   if (stat.mul_done) pc_next = ctrl.target;
            OP_BRZ:    pc_next = stat.el_zero ? ctrl.target : pc_reg + 1'b1;
            OP_BRE:    pc_next = !stat.el_lsb ? ctrl.target : pc_reg + 1'b1;
            OP_EMIT:   if (stat.out_free) pc_next = ctrl.target;
            default:   pc_next = PC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mexp_dpath.sv]
// mexp_dpath: configuration registers, working registers (accumulator,
// running square, exponent bits left), operand selection and output register.
// Depends on mexp_pkg.
`default_nettype none

module mexp_dpath
    import mexp_pkg::*;
#(
    parameter int WIDTH = MEXP_WIDTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [FIELD_W-1:0]    cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [FIELD_W-1:0]    s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [FIELD_W-1:0]    m_tdata,
    input  wire ctrl_word_t            ctrl,
    output stat_t                      stat,
    output logic                       mul_start,
    output logic      [WIDTH-1:0]      mul_a,
    output logic      [WIDTH-1:0]      mul_b,
    output logic      [WIDTH-1:0]      mul_m,
    input  wire logic                  mul_done,
    input  wire logic [WIDTH-1:0]      mul_p
);

    logic [WIDTH-1:0]   mod_reg;
    logic [WIDTH-1:0]   exp_reg;
    logic [WIDTH-1:0]   acc_reg, acc_next;
    logic [WIDTH-1:0]   rs_reg, rs_next;
    logic [WIDTH-1:0]   el_reg, el_next;
    logic               out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] out_data_reg, out_data_next;
    logic [WIDTH-1:0]   one_red;
    logic               in_fire;
    logic               out_free;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= WIDTH'(1);
            exp_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_MODULUS:  mod_reg <= WIDTH'(cfg_wdata);
                CFG_EXPONENT: exp_reg <= WIDTH'(cfg_wdata);
                default:      ;
            endcase
        end
    end

    // handshakes
    assign s_tready = (ctrl.op == OP_ACCEPT);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // one reduced modulo the modulus, used to reduce the message
    assign one_red = (mod_reg == WIDTH'(1)) ? '0 : WIDTH'(1);

    // multiplier operands
    always_comb begin
        mul_start = (ctrl.op == OP_MUL);
        mul_m     = mod_reg;
        unique case (ctrl.a_sel)
            OPND_ONE: mul_a = one_red;
            OPND_RS:  mul_a = rs_reg;
            OPND_ACC: mul_a = acc_reg;
            default:  mul_a = rs_reg;
        endcase
        unique case (ctrl.b_sel)
            OPND_ONE: mul_b = one_red;
            OPND_RS:  mul_b = rs_reg;
            OPND_ACC: mul_b = acc_reg;
            default:  mul_b = rs_reg;
        endcase
    end

    // working registers and output register
    always_comb begin
        acc_next       = acc_reg;
        rs_next        = rs_reg;
        el_next        = el_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (ctrl.op)
            OP_ACCEPT: begin
                if (in_fire) begin
                    acc_next = WIDTH'(1);
                    rs_next  = WIDTH'(s_tdata);
                    el_next  = exp_reg;
                end
            end
            OP_WAIT: begin
                if (mul_done) begin
                    if (ctrl.dst == DST_RS) begin
                        rs_next = mul_p;
                    end else if (ctrl.dst == DST_ACC) begin
                        acc_next = mul_p;
                    end
                    if (ctrl.shift_el) begin
                        el_next = el_reg >> 1;
                    end
                end
            end
            OP_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = FIELD_W'(acc_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        acc_reg      <= acc_next;
        rs_reg       <= rs_next;
        el_reg       <= el_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign stat = '{in_fire:  in_fire,
                    mul_done: mul_done,
                    el_zero:  (el_reg == '0),
                    el_lsb:   el_reg[0],
                    out_free: out_free};

endmodule

`default_nettype wire

[rtl/core/modular_exponentiation_top.sv]
// modular_exponentiation_top: message^exponent mod modulus, right-to-left
// square-and-multiply. Instantiates mexp_useq, mexp_dpath, mexp_modmul.
//
//   channel   dir   ports                        contents
//   s_        in    s_tvalid s_tready s_tdata    message [31:0]
//   m_        out   m_tvalid m_tready m_tdata    power_mod [31:0]
//   cfg_      in    cfg_we cfg_addr cfg_wdata    0: modulus, 1: exponent
//
// One item at a time. The bit-serial multiplier sets the rate: each item
// takes 1+k+h modular products, k = exponent bit length, h = its ones.
// Reset is synchronous, active low; modulus resets to 1, exponent to 0.
// The result waits in the output register while the next message is taken.
`default_nettype none

module modular_exponentiation_top
    import mexp_pkg::*;
#(
    parameter int WIDTH = MEXP_WIDTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [FIELD_W-1:0]    cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [FIELD_W-1:0]    s_tdata,    // [31:0] message
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [FIELD_W-1:0]    m_tdata     // [31:0] power_mod
);

    ctrl_word_t       ctrl;
    stat_t            stat;
    logic             mul_start;
    logic [WIDTH-1:0] mul_a;
    logic [WIDTH-1:0] mul_b;
    logic [WIDTH-1:0] mul_m;
    logic             mul_done;
    logic [WIDTH-1:0] mul_p;

    // microcode sequencer
    mexp_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // registers and handshakes
    mexp_dpath #(
        .WIDTH (WIDTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .ctrl      (ctrl),
        .stat      (stat),
        .mul_start (mul_start),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .mul_m     (mul_m),
        .mul_done  (mul_done),
        .mul_p     (mul_p)
    );

    // shared modular multiplier
    mexp_modmul #(
        .WIDTH (WIDTH)
    ) u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (mul_m),
        .done    (mul_done),
        .product (mul_p)
    );

endmodule

`default_nettype wire

[rtl/core/mexp_checker.sv]
// mexp_checker: port-level assertions for modular_exponentiation_top and the
// bind that attaches them. Depends on mexp_pkg.
`default_nettype none

module mexp_checker
    import mexp_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [FIELD_W-1:0]    m_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result keeps its data
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // one message at a time: no second beat right after an accepted one
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // a result needs at least one multiplication after its message
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared right after message beat");

    // reset empties the output register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (.*);

`default_nettype wire
